### hdl/return_and_indirect_target_predictor_core_macros.svh
// Assertion macros used by the predictor checker file.
`ifndef RETURN_AND_INDIRECT_TARGET_PREDICTOR_CORE_MACROS_SVH
`define RETURN_AND_INDIRECT_TARGET_PREDICTOR_CORE_MACROS_SVH

// same-cycle implication under reset
`define RAITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("predictor assertion failed");

// next-cycle implication under reset
`define RAITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("predictor assertion failed");

`endif

### hdl/raitp_pkg.sv
// Shared types, codes and a helper function of the return and indirect target predictor.
package raitp_pkg;

    localparam int ADDR_W    = 64;
    localparam int KIND_W    = 3;
    localparam int SIZE_W    = 4;
    localparam int MOD_W     = 17;

    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;

    localparam int OUT_TARGET_LSB = 0;
    localparam int OUT_TAKEN_BIT  = 64;
    localparam int OUT_HANDLED_BIT = 65;

    localparam logic [KIND_W-1:0] KIND_COND  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DCALL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ICALL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RET   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IJMP  = 3'd4;

    localparam logic [ADDR_W-1:0] LEARN_LIMIT = 64'd10;
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd4;

    // fold one byte, msb first, into a running remainder modulo m
    function automatic logic [MOD_W-1:0] mod_byte(input logic [MOD_W-1:0] rem,
                                                  input logic [7:0] b,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W-1:0] t;
        t = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {t[MOD_W-2:0], b[i]};
            if (t >= m) begin
                t = t - m;
            end
        end
        return t;
    endfunction

endpackage

### hdl/return_and_indirect_target_predictor_core.sv
// Return address stack and indirect target predictor, top level.
//
// Input channel s_axis: one item per handshake, a predict lookup (mode 0) or
// a resolved-branch update (mode 1). tuser carries mode and kind, tdata the
// branch address, the resolved target and the taken bit.
// Output channel m_axis: exactly one result item per input item, in order,
// holding the predicted target, the unconditional flag and handled.
// The tables live in three RAMs with registered read data: return stack,
// indirect target table and call size table. An item is read, modified and
// written back before the next one is taken, so no forwarding is needed.
// States per item after accept: S_MODT for the byte-serial reduction of the
// indirect index when the table depth is not a power of two (indirect kinds),
// S_ISSUE, S_DATA1 for returns and indirect predicts, then for returns S_MODS
// when the call size depth is not a power of two, S_SRD and S_DATA2, and last
// S_OUT, which loads the result and returns to S_IDLE to accept the next item.
// After reset a clearing pass of max(INDIRECT_ENTRIES, CALL_SIZE_ENTRIES,
// STACK_DEPTH) addresses (4096 by default) initializes the RAMs; s_axis_tready
// stays low meanwhile. A stalled receiver holds the result in the output
// register; the next item may be accepted and worked on, and its result
// waits until the register is free.
module return_and_indirect_target_predictor_core #(
    parameter int INDIRECT_ENTRIES  = 4096,
    parameter int STACK_DEPTH       = 32,
    parameter int CALL_SIZE_ENTRIES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: ip[63:0], resolved_target[127:64], was_taken[128], zero fill
    input  logic [raitp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode[0], kind[3:1]
    input  logic [raitp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: predicted_target[63:0], uncond[64], handled[65], zero fill
    output logic [raitp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import raitp_pkg::*;

    localparam int TW    = $clog2(INDIRECT_ENTRIES);
    localparam int SPW   = $clog2(STACK_DEPTH);
    localparam int SW    = $clog2(CALL_SIZE_ENTRIES);
    localparam int CLR_N = (INDIRECT_ENTRIES > CALL_SIZE_ENTRIES) ?
                           ((INDIRECT_ENTRIES > STACK_DEPTH) ? INDIRECT_ENTRIES : STACK_DEPTH) :
                           ((CALL_SIZE_ENTRIES > STACK_DEPTH) ? CALL_SIZE_ENTRIES : STACK_DEPTH);
    localparam int CLR_W = $clog2(CLR_N) + 1;
    localparam bit IND_POW2 = ((1 << TW) == INDIRECT_ENTRIES);
    localparam bit CS_POW2  = ((1 << SW) == CALL_SIZE_ENTRIES);
    localparam logic [MOD_W-1:0] IND_M = MOD_W'(INDIRECT_ENTRIES);
    localparam logic [MOD_W-1:0] CS_M  = MOD_W'(CALL_SIZE_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MODT, S_ISSUE, S_DATA1, S_MODS, S_SRD, S_DATA2, S_OUT
    } t_state;

    t_state              r_state;
    logic [CLR_W-1:0]    r_clr_cnt;
    logic                r_mode;
    logic [KIND_W-1:0]   r_kind;
    logic [ADDR_W-1:0]   r_ip;
    logic [ADDR_W-1:0]   r_target;
    logic                r_taken;
    logic [SPW-1:0]      r_sp;
    logic [ADDR_W-1:0]   r_hist;
    logic [TW-1:0]       r_tidx;
    logic [SW-1:0]       r_sidx;
    logic [ADDR_W-1:0]   r_top;
    logic [ADDR_W-1:0]   r_mval;
    logic [MOD_W-1:0]    r_mrem;
    logic [2:0]          r_mcnt;
    logic [ADDR_W-1:0]   r_pred;
    logic                r_hd;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_pred;
    logic                r_out_at;
    logic                r_out_hd;

    logic                in_kind_ind;
    logic                in_mode;
    logic [KIND_W-1:0]   in_kind;
    logic [ADDR_W-1:0]   in_hash;
    logic                is_ind;
    logic                is_push;
    logic                clearing;
    logic [MOD_W-1:0]    mod_next;
    logic [ADDR_W-1:0]   ret_gap;
    logic                learn;
    logic [SPW-1:0]      sp_inc;
    logic [SPW-1:0]      sp_dec;

    logic                stk_we;
    logic [SPW-1:0]      stk_waddr;
    logic [ADDR_W-1:0]   stk_wdata;
    logic [ADDR_W-1:0]   stk_rdata;
    logic                tbl_we;
    logic [TW-1:0]       tbl_waddr;
    logic [ADDR_W-1:0]   tbl_wdata;
    logic [ADDR_W-1:0]   tbl_rdata;
    logic                cs_we;
    logic [SW-1:0]       cs_waddr;
    logic [SIZE_W-1:0]   cs_wdata;
    logic [SIZE_W-1:0]   cs_rdata;

    assign in_mode     = s_axis_tuser[0];
    assign in_kind     = s_axis_tuser[3:1];
    assign in_kind_ind = (in_kind == KIND_ICALL) || (in_kind == KIND_IJMP);
    assign in_hash     = {2'b00, s_axis_tdata[63:2]} ^ r_hist;

    assign is_ind   = (r_kind == KIND_ICALL) || (r_kind == KIND_IJMP);
    assign is_push  = !r_mode && ((r_kind == KIND_DCALL) || (r_kind == KIND_ICALL));
    assign clearing = (r_state == S_CLEAR);

    assign mod_next = mod_byte(r_mrem, r_mval[63:56], (r_state == S_MODT) ? IND_M : CS_M);

    assign ret_gap = (r_top > r_target) ? (r_top - r_target) : (r_target - r_top);
    assign learn   = (ret_gap <= LEARN_LIMIT);

    assign sp_inc = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - 1'b1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - 66){1'b0}}, r_out_hd, r_out_at, r_out_pred};

    always_comb begin
        if (clearing) begin
            stk_we    = (r_clr_cnt < CLR_W'(STACK_DEPTH));
            stk_waddr = r_clr_cnt[SPW-1:0];
            stk_wdata = '0;
            tbl_we    = (r_clr_cnt < CLR_W'(INDIRECT_ENTRIES));
            tbl_waddr = r_clr_cnt[TW-1:0];
            tbl_wdata = '0;
            cs_we     = (r_clr_cnt < CLR_W'(CALL_SIZE_ENTRIES));
            cs_waddr  = r_clr_cnt[SW-1:0];
            cs_wdata  = SIZE_RESET;
        end else begin
            stk_we    = ((r_state == S_ISSUE) && is_push) ||
                        ((r_state == S_DATA1) && r_mode && (r_kind == KIND_RET));
            stk_waddr = r_sp;
            stk_wdata = (r_state == S_ISSUE) ? r_ip : '0;
            tbl_we    = (r_state == S_ISSUE) && r_mode && is_ind;
            tbl_waddr = r_tidx;
            tbl_wdata = r_target;
            cs_we     = (r_state == S_DATA2) && r_mode && learn;
            cs_waddr  = r_sidx;
            cs_wdata  = ret_gap[SIZE_W-1:0];
        end
    end

    raitp_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (r_sp),
        .o_rdata (stk_rdata)
    );

    raitp_ram #(.WIDTH(ADDR_W), .DEPTH(INDIRECT_ENTRIES)) u_targets (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_tidx),
        .o_rdata (tbl_rdata)
    );

    raitp_ram #(.WIDTH(SIZE_W), .DEPTH(CALL_SIZE_ENTRIES)) u_sizes (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_raddr (r_sidx),
        .o_rdata (cs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_sp        <= '0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == CLR_W'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode   <= in_mode;
                        r_kind   <= in_kind;
                        r_ip     <= s_axis_tdata[63:0];
                        r_target <= s_axis_tdata[127:64];
                        r_taken  <= s_axis_tdata[128];
                        r_pred   <= '0;
                        r_hd     <= 1'b0;
                        r_tidx   <= in_hash[TW-1:0];
                        r_mval   <= in_hash;
                        r_mrem   <= '0;
                        r_mcnt   <= '0;
                        if (!in_mode && ((in_kind == KIND_DCALL) || (in_kind == KIND_ICALL))) begin
                            r_sp <= sp_inc;
                        end
                        r_state <= (in_kind_ind && !IND_POW2) ? S_MODT : S_ISSUE;
                    end
                end
                S_MODT: begin
                    r_mrem <= mod_next;
                    r_mval <= r_mval << 8;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 3'd7) begin
                        r_tidx  <= mod_next[TW-1:0];
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_mode && (r_kind == KIND_COND)) begin
                        r_hist <= {r_hist[ADDR_W-2:0], r_taken};
                    end
                    if ((r_kind == KIND_RET) || (!r_mode && is_ind)) begin
                        r_state <= S_DATA1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DATA1: begin
                    if (r_kind == KIND_RET) begin
                        r_top  <= stk_rdata;
                        r_mval <= stk_rdata;
                        r_mrem <= '0;
                        r_mcnt <= '0;
                        r_sidx <= stk_rdata[SW-1:0];
                        if (r_mode) begin
                            r_sp <= sp_dec;
                        end
                        r_state <= CS_POW2 ? S_SRD : S_MODS;
                    end else begin
                        r_pred  <= tbl_rdata;
                        r_hd    <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_MODS: begin
                    r_mrem <= mod_next;
                    r_mval <= r_mval << 8;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 3'd7) begin
                        r_sidx  <= mod_next[SW-1:0];
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= S_DATA2;
                end
                S_DATA2: begin
                    if (!r_mode) begin
                        r_pred <= r_top + ADDR_W'(cs_rdata);
                        r_hd   <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_pred  <= r_pred;
                        r_out_at    <= (r_kind != KIND_COND);
                        r_out_hd    <= r_hd;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/raitp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module raitp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/raitp_checker.sv
// Port-level checker of the predictor and its bind to the top level.
`include "return_and_indirect_target_predictor_core_macros.svh"

module raitp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [raitp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [raitp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [raitp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import raitp_pkg::*;

    `RAITP_ASSERT_NOW(a_zero_when_unhandled, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tdata[OUT_HANDLED_BIT],
        m_axis_tdata[OUT_TAKEN_BIT-1:OUT_TARGET_LSB] == '0)

    `RAITP_ASSERT_NOW(a_handled_taken, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[OUT_HANDLED_BIT],
        m_axis_tdata[OUT_TAKEN_BIT])

    `RAITP_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready,
        !s_axis_tready)

    `RAITP_ASSERT_NOW(a_no_accept_after_reset, i_clk, i_rst_n,
        !$past(i_rst_n),
        !s_axis_tready)

    `RAITP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind return_and_indirect_target_predictor_core raitp_checker u_raitp_checker (.*);
